// ===== rtl/lac_pkg.sv =====
// Shared constants for the layer alpha compositor.
package lac_pkg;

	typedef enum logic {
		OP_DESC   = 1'b0,
		OP_SAMPLE = 1'b1
	} lac_op_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

endpackage

// ===== rtl/layer_alpha_compositor_top.sv =====
// Layer alpha compositor: descriptor table, per-pixel blend accumulator and result queue.
//
// Slave channel: one beat per item. tuser[0] is op (0 writes a layer
// descriptor, 1 feeds one layer sample), tuser[1] marks the bottom-most sample
// of a pixel, tlast marks the topmost sample. Samples of one pixel arrive from
// the bottom slot upward. Master channel: one beat per pixel, on each op 1 beat
// that carries tlast, with the composited ARGB colour in tdata and the written
// flag in tuser.
// Throughput is one beat per cycle while s_tready is high. The descriptor
// table is a memory with a registered read: a beat reads its slot in the accept
// cycle and is blended against the accumulator in the next, so a result passes
// the stage 1 registers, then enters the 4-deep output queue and shows on the
// master side right after that write.
// A descriptor write is visible to the very next beat.
// Reset disables every slot (per-slot valid bits) and clears the accumulator
// and the output queue; the table memory itself is not swept.
// When the receiver stalls, results collect in the output queue and tready on
// the slave side drops once the queue and the in-flight beat would fill it.
module layer_alpha_compositor_top
	import lac_pkg::*;
#(
	parameter int LAYERS     = 16,
	parameter int COORD_BITS = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// layer_slot, coord_x, coord_y, layer_width, layer_height, layer_enable,
	// layer_color, fb_color, zero fill
	input  logic [((69+4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// op, first
	input  logic [1:0]                         s_tuser,
	input  logic                               s_tlast,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pixel_color
	output logic [31:0]                        m_tdata,
	// written
	output logic                               m_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready
);

	localparam int CB      = COORD_BITS;
	localparam int IDX_W   = $clog2(LAYERS);
	localparam int ENTRY_W = 4*CB + 1;
	localparam int X_LO    = 4;
	localparam int Y_LO    = X_LO + CB;
	localparam int W_LO    = Y_LO + CB;
	localparam int H_LO    = W_LO + CB;
	localparam int EN_B    = H_LO + CB;
	localparam int LC_LO   = EN_B + 1;
	localparam int FB_LO   = LC_LO + 32;

	// input field split
	logic [3:0]          in_slot;
	logic [CB-1:0]       in_x;
	logic [CB-1:0]       in_y;
	logic [CB-1:0]       in_w;
	logic [CB-1:0]       in_h;
	logic                in_en;
	logic [31:0]         in_lc;
	logic [31:0]         in_fb;
	lac_op_t             in_op;
	logic                in_first;
	logic                in_slot_ok;
	logic [IDX_W-1:0]    in_idx;
	logic                accept;

	assign in_slot    = s_tdata[3:0];
	assign in_x       = s_tdata[X_LO +: CB];
	assign in_y       = s_tdata[Y_LO +: CB];
	assign in_w       = s_tdata[W_LO +: CB];
	assign in_h       = s_tdata[H_LO +: CB];
	assign in_en      = s_tdata[EN_B];
	assign in_lc      = s_tdata[LC_LO +: 32];
	assign in_fb      = s_tdata[FB_LO +: 32];
	assign in_op      = lac_op_t'(s_tuser[0]);
	assign in_first   = s_tuser[1];
	assign in_slot_ok = (32'(in_slot) < LAYERS);
	assign in_idx     = IDX_W'(in_slot);
	assign accept     = s_tvalid && s_tready;

	// descriptor table: {ox, oy, w, h, en}
	logic [ENTRY_W-1:0] desc_mem [LAYERS];
	logic [LAYERS-1:0]  desc_vld_q;

	always_ff @(posedge clk) begin
		if (accept && in_op == OP_DESC && in_slot_ok) begin
			desc_mem[in_idx] <= {in_x, in_y, in_w, in_h, in_en};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_vld_q <= '0;
		end else if (accept && in_op == OP_DESC && in_slot_ok) begin
			desc_vld_q[in_idx] <= 1'b1;
		end
	end

	// stage 1: table read and sample hold
	logic               vld_s1;
	logic [ENTRY_W-1:0] desc_s1;
	logic               hit_s1;
	logic [CB-1:0]      x_s1;
	logic [CB-1:0]      y_s1;
	logic [31:0]        lc_s1;
	logic [31:0]        fb_s1;
	logic               first_s1;
	logic               last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept && in_op == OP_SAMPLE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_op == OP_SAMPLE) begin
			desc_s1  <= desc_mem[in_idx];
			hit_s1   <= in_slot_ok && desc_vld_q[in_idx];
			x_s1     <= in_x;
			y_s1     <= in_y;
			lc_s1    <= in_lc;
			fb_s1    <= in_fb;
			first_s1 <= in_first;
			last_s1  <= s_tlast;
		end
	end

	// stage 2: coverage, blend, accumulator update
	logic signed [CB:0] dx;
	logic signed [CB:0] dy;
	logic [CB-1:0]      d_ox;
	logic [CB-1:0]      d_oy;
	logic [CB-1:0]      d_w;
	logic [CB-1:0]      d_h;
	logic               d_en;
	logic               covered;
	logic [7:0]         alpha;
	logic [7:0]         inv_alpha;
	logic [31:0]        old_c;
	logic               old_w;
	logic [15:0]        mix_sum [3];
	logic [31:0]        mix_c;
	logic [31:0]        nxt_c;
	logic               nxt_w;
	logic [31:0]        acc_color_q;
	logic               acc_written_q;

	assign {d_ox, d_oy, d_w, d_h, d_en} = desc_s1;
	assign dx = {x_s1[CB-1], x_s1} - {d_ox[CB-1], d_ox};
	assign dy = {y_s1[CB-1], y_s1} - {d_oy[CB-1], d_oy};
	assign covered = hit_s1 && d_en
		&& !dx[CB] && (dx < $signed({1'b0, d_w}))
		&& !dy[CB] && (dy < $signed({1'b0, d_h}));
	assign alpha     = lc_s1[31:24];
	assign inv_alpha = ALPHA_OPAQUE - alpha;
	assign old_c     = first_s1 ? fb_s1 : acc_color_q;
	assign old_w     = first_s1 ? 1'b0 : acc_written_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mix_sum[i] = 16'({8'd0, old_c[8*i +: 8]} * {8'd0, inv_alpha})
				+ 16'({8'd0, lc_s1[8*i +: 8]} * {8'd0, alpha});
		end
		mix_c = {ALPHA_OPAQUE, mix_sum[2][15:8], mix_sum[1][15:8], mix_sum[0][15:8]};
		nxt_c = old_c;
		nxt_w = old_w;
		if (covered) begin
			if (alpha == ALPHA_OPAQUE) begin
				nxt_c = lc_s1;
				nxt_w = 1'b1;
			end else if (alpha != ALPHA_CLEAR) begin
				nxt_c = mix_c;
				nxt_w = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_color_q   <= '0;
			acc_written_q <= 1'b0;
		end else if (vld_s1) begin
			acc_color_q   <= nxt_c;
			acc_written_q <= nxt_w;
		end
	end

	// output queue
	logic [32:0]          out_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign push     = vld_s1 && last_s1;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign {m_tuser, m_tdata} = out_q[rd_ptr_q];
	assign s_tready = ((cnt_q + OUT_CNT_W'(vld_s1)) < OUT_CNT_W'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			out_q[wr_ptr_q] <= {nxt_w, nxt_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
